@@ rtl/rxf_pkg.sv @@
// ----------------------------------------------------------------------------
// rxf_pkg
// Shared constants, mode codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rxf_pkg;

    localparam int COORD_W  = 32;   // Q16.16 coordinate width
    localparam int ANGLE_W  = 16;   // angle output width
    localparam int CORDIC_N = 16;   // CORDIC iterations
    localparam int FRAC_W   = 32;   // interpolation fraction, unsigned Q0.32
    localparam int ATAN_W   = 34;   // CORDIC angle accumulator, units of pi/2^31

    localparam logic [1:0] MODE_MAX   = 2'b01;
    localparam logic [1:0] MODE_MIN   = 2'b10;
    localparam logic [1:0] MODE_RESET = MODE_MAX;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [ATAN_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            5'd24:   v = 34'sd41;
            5'd25:   v = 34'sd20;
            5'd26:   v = 34'sd10;
            5'd27:   v = 34'sd5;
            5'd28:   v = 34'sd3;
            5'd29:   v = 34'sd1;
            5'd30:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/rxf_if.sv @@
// ----------------------------------------------------------------------------
// rxf interfaces
// Valid/ready channels for orbit points, extremum results and mode writes.
// ----------------------------------------------------------------------------
interface rxf_pt_if #(parameter int CW = 32) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] sample_time;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, sample_time, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, sample_time, output ready);
endinterface

interface rxf_ext_if #(parameter int CW = 32, parameter int AW = 16) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] cross_time;
    logic signed [AW-1:0] cross_angle;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
    logic        [CW-1:0] cross_radius;
    logic                 is_maximum;
    modport source (output valid, cross_time, cross_angle, cross_x, cross_y, cross_radius,
                    is_maximum, input ready);
    modport sink   (input valid, cross_time, cross_angle, cross_x, cross_y, cross_radius,
                    is_maximum, output ready);
endinterface

interface rxf_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] mode_select;
    modport source (output valid, mode_select, input ready);
    modport sink   (input valid, mode_select, output ready);
endinterface

@@ rtl/rxf_front.sv @@
// ----------------------------------------------------------------------------
// rxf_front
// Forms the radial rate per point, detects strict sign changes, queues events.
// ----------------------------------------------------------------------------
module rxf_front #(
    parameter int CW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    rxf_pt_if.sink            pt,
    rxf_cfg_if.sink           cfg,
    output logic              q_push,
    output logic [6*CW+2*(2*CW-1):0] q_data,
    input  logic              q_full
);
    import rxf_pkg::*;

    localparam int RW = 2 * CW;
    localparam logic signed [RW:0] RMAX = {2'b00, {(RW-1){1'b1}}};
    localparam logic signed [RW:0] RMIN = -RMAX;

    logic [1:0]           mode_reg;
    logic                 s1_valid_reg;
    logic signed [RW-1:0] pxv_reg, pyv_reg;
    logic signed [CW-1:0] x_reg, y_reg, t_reg;

    logic                 have_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg, prev_t_reg;
    logic signed [RW-1:0] prev_rate_reg;

    logic signed [RW-1:0] pxv, pyv;
    logic signed [RW:0]   sum;
    logic signed [RW-1:0] rate;
    logic                 rate_neg, rate_pos, prev_neg, prev_pos;
    logic                 is_max, is_min, event_hit, s1_go;
    logic [RW-2:0]        mag0, mag1;

    assign cfg.ready = 1'b1;
    assign pxv = pt.pos_x * pt.vel_x;
    assign pyv = pt.pos_y * pt.vel_y;

    always_comb
    begin
        sum = {pxv_reg[RW-1], pxv_reg} + {pyv_reg[RW-1], pyv_reg};
        if (sum > RMAX)
            rate = RMAX[RW-1:0];
        else if (sum < RMIN)
            rate = RMIN[RW-1:0];
        else
            rate = sum[RW-1:0];
    end

    assign rate_neg  = rate[RW-1];
    assign rate_pos  = !rate[RW-1] && (rate != '0);
    assign prev_neg  = prev_rate_reg[RW-1];
    assign prev_pos  = !prev_rate_reg[RW-1] && (prev_rate_reg != '0);
    assign is_max    = have_reg && prev_pos && rate_neg;
    assign is_min    = have_reg && prev_neg && rate_pos;
    assign event_hit = (is_max && ((mode_reg & MODE_MAX) != '0))
                    || (is_min && ((mode_reg & MODE_MIN) != '0));
    assign s1_go     = s1_valid_reg && (!event_hit || !q_full);
    assign q_push    = s1_go && event_hit;
    assign pt.ready  = !s1_valid_reg || s1_go;

    // saturated rate never reaches the most negative code, so magnitude fits
    assign mag0 = prev_neg ? (RW-1)'(-prev_rate_reg) : prev_rate_reg[RW-2:0];
    assign mag1 = rate_neg ? (RW-1)'(-rate) : rate[RW-2:0];

    assign q_data = {prev_x_reg, prev_y_reg, prev_t_reg, x_reg, y_reg, t_reg,
                     mag0, mag1, is_max};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            s1_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_t_reg    <= '0;
            prev_rate_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                mode_reg <= cfg.mode_select;
            if (pt.valid && pt.ready)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
            begin
                have_reg      <= 1'b1;
                prev_x_reg    <= x_reg;
                prev_y_reg    <= y_reg;
                prev_t_reg    <= t_reg;
                prev_rate_reg <= rate;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt.valid && pt.ready)
        begin
            pxv_reg <= pxv;
            pyv_reg <= pyv;
            x_reg   <= pt.pos_x;
            y_reg   <= pt.pos_y;
            t_reg   <= pt.sample_time;
        end
    end

endmodule

@@ rtl/rxf_fifo.sv @@
// ----------------------------------------------------------------------------
// rxf_fifo
// Small synchronous queue between the detect front and the solver back.
// ----------------------------------------------------------------------------
module rxf_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wr_data,
    input  logic          pop,
    output logic [DW-1:0] rd_data,
    output logic          full,
    output logic          empty
);
    import rxf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/rxf_back.sv @@
// ----------------------------------------------------------------------------
// rxf_back
// Sequencer: fraction divide, interpolation, CORDIC angle and integer sqrt.
// ----------------------------------------------------------------------------
module rxf_back #(
    parameter int CW = 32,
    parameter int AW = 16,
    parameter int CN = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  logic [6*CW+2*(2*CW-1):0] q_data,
    output logic                     q_pop,
    rxf_ext_if.source                ext
);
    import rxf_pkg::*;

    localparam int RW      = 2 * CW;
    localparam int XW      = CW + 3;
    localparam int MA_W    = CW + 1;
    localparam int MB_W    = (FRAC_W > CW + 1) ? FRAC_W : CW + 1;
    localparam int SH      = 32 - AW;
    localparam int CNT_MAX = (FRAC_W > CN) ? ((FRAC_W > CW) ? FRAC_W : CW)
                                           : ((CN > CW) ? CN : CW);
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam logic signed [ATAN_W-1:0] RND     = ATAN_W'(1) << (SH - 1);
    localparam logic signed [ATAN_W-1:0] QUARTER = ATAN_W'(1) << 30;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LMUL, S_LADD, S_SQX, S_SQY, S_ROT, S_CORD, S_SQRT, S_DONE
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               idx_reg;
    logic signed [CW-1:0]     a0_x_reg, a0_y_reg, a0_t_reg, a1_x_reg, a1_y_reg, a1_t_reg;
    logic                     is_max_reg;
    logic [RW-1:0]            rem_reg, d_reg;
    logic [FRAC_W-1:0]        f_reg;
    logic [MA_W+MB_W-1:0]     prod_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg, ct_reg;
    logic [RW-1:0]            n_reg, op_reg, res_reg, one_reg;
    logic signed [XW-1:0]     x_reg, y_reg;
    logic signed [ATAN_W-1:0] z_reg;
    logic                     origin_reg;
    logic                     out_valid_reg;

    logic signed [CW-1:0]     e_px, e_py, e_pt, e_x, e_y, e_t;
    logic [RW-2:0]            e_m0, e_m1;
    logic                     e_max;

    logic                     carry, take;
    logic [RW-1:0]            shl;
    logic signed [CW-1:0]     a0_sel, a1_sel;
    logic signed [CW:0]       diff, lres;
    logic [CW:0]              dmag, off, xmag, ymag;
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [MA_W+MB_W-1:0]     prod;
    logic signed [XW-1:0]     xs, ys, cxe, cye;
    logic [RW-1:0]            trial;
    logic signed [ATAN_W-1:0] zr;
    logic                     load_out;

    assign {e_px, e_py, e_pt, e_x, e_y, e_t, e_m0, e_m1, e_max} = q_data;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    // restoring divide step
    assign carry = rem_reg[RW-1];
    assign shl   = {rem_reg[RW-2:0], 1'b0};
    assign take  = carry || (shl >= d_reg);

    always_comb
    begin
        case (idx_reg)
            2'd0:    begin a0_sel = a0_x_reg; a1_sel = a1_x_reg; end
            2'd1:    begin a0_sel = a0_y_reg; a1_sel = a1_y_reg; end
            default: begin a0_sel = a0_t_reg; a1_sel = a1_t_reg; end
        endcase
    end

    assign diff = {a1_sel[CW-1], a1_sel} - {a0_sel[CW-1], a0_sel};
    assign dmag = diff[CW] ? -diff : diff;
    assign off  = prod_reg[FRAC_W +: CW+1];
    assign lres = diff[CW] ? ({a0_sel[CW-1], a0_sel} - $signed(off))
                           : ({a0_sel[CW-1], a0_sel} + $signed(off));
    assign xmag = cx_reg[CW-1] ? -{cx_reg[CW-1], cx_reg} : {cx_reg[CW-1], cx_reg};
    assign ymag = cy_reg[CW-1] ? -{cy_reg[CW-1], cy_reg} : {cy_reg[CW-1], cy_reg};

    // one shared multiplier for interpolation and the squares
    always_comb
    begin
        case (state_reg)
            S_SQX:   begin mul_a = xmag; mul_b = MB_W'(xmag); end
            S_SQY:   begin mul_a = ymag; mul_b = MB_W'(ymag); end
            default: begin mul_a = dmag; mul_b = MB_W'(f_reg); end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign cxe   = XW'(cx_reg);
    assign cye   = XW'(cy_reg);
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign trial = res_reg + one_reg;
    assign zr    = (z_reg + RND) >>> SH;

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || ext.ready);
    assign ext.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (ext.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_DIV;
                        cnt_reg   <= '0;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(FRAC_W-1))
                    begin
                        state_reg <= S_LMUL;
                        idx_reg   <= '0;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_LMUL:
                    state_reg <= S_LADD;
                S_LADD:
                begin
                    if (idx_reg == 2'd2)
                        state_reg <= S_SQX;
                    else
                        state_reg <= S_LMUL;
                    idx_reg <= idx_reg + 1'b1;
                end
                S_SQX:
                    state_reg <= S_SQY;
                S_SQY:
                    state_reg <= S_ROT;
                S_ROT:
                begin
                    state_reg <= S_CORD;
                    cnt_reg   <= '0;
                end
                S_CORD:
                begin
                    if (cnt_reg == CNT_W'(CN-1))
                    begin
                        state_reg <= S_SQRT;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_SQRT:
                begin
                    if (cnt_reg == CNT_W'(CW-1))
                        state_reg <= S_DONE;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DONE:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                a0_x_reg   <= e_px;
                a0_y_reg   <= e_py;
                a0_t_reg   <= e_pt;
                a1_x_reg   <= e_x;
                a1_y_reg   <= e_y;
                a1_t_reg   <= e_t;
                is_max_reg <= e_max;
                rem_reg    <= RW'(e_m0);
                d_reg      <= RW'(e_m0) + RW'(e_m1);
                f_reg      <= '0;
            end
            S_DIV:
            begin
                rem_reg <= take ? (shl - d_reg) : shl;
                f_reg   <= {f_reg[FRAC_W-2:0], take};
            end
            S_LMUL:
                prod_reg <= prod;
            S_LADD:
            begin
                case (idx_reg)
                    2'd0:    cx_reg <= lres[CW-1:0];
                    2'd1:    cy_reg <= lres[CW-1:0];
                    default: ct_reg <= lres[CW-1:0];
                endcase
            end
            S_SQX:
                prod_reg <= prod;
            S_SQY:
            begin
                prod_reg <= prod;
                n_reg    <= prod_reg[RW-1:0];
            end
            S_ROT:
            begin
                op_reg     <= n_reg + prod_reg[RW-1:0];
                res_reg    <= '0;
                one_reg    <= RW'(1) << (RW - 2);
                origin_reg <= (cx_reg == '0) && (cy_reg == '0);
                // quarter-turn pre-rotation into the right half plane
                if (!cx_reg[CW-1])
                begin
                    x_reg <= cxe;
                    y_reg <= cye;
                    z_reg <= '0;
                end
                else if (!cy_reg[CW-1])
                begin
                    x_reg <= cye;
                    y_reg <= -cxe;
                    z_reg <= QUARTER;
                end
                else
                begin
                    x_reg <= -cye;
                    y_reg <= cxe;
                    z_reg <= -QUARTER;
                end
            end
            S_CORD:
            begin
                if (!y_reg[XW-1] && (y_reg != '0))
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_lut(cnt_reg[4:0]);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_lut(cnt_reg[4:0]);
                end
            end
            S_SQRT:
            begin
                if (op_reg >= trial)
                begin
                    op_reg  <= op_reg - trial;
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                one_reg <= one_reg >> 2;
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            ext.cross_time   <= ct_reg;
            ext.cross_angle  <= origin_reg ? '0 : zr[AW-1:0];
            ext.cross_x      <= cx_reg;
            ext.cross_y      <= cy_reg;
            ext.cross_radius <= res_reg[CW-1:0];
            ext.is_maximum   <= is_max_reg;
        end
    end

endmodule

@@ rtl/radial_extremum_finder.sv @@
// ----------------------------------------------------------------------------
// radial_extremum_finder
// Finds radial maxima/minima in a stream of orbit points and interpolates them.
// ----------------------------------------------------------------------------
// Usage:
//   pt  : one orbit point per beat (position, velocity, time, Q16.16).
//   ext : one result beat per reported extremum (time, angle, x, y, radius).
//   cfg : writes mode_select (bit0 maxima, bit1 minima); always ready.
// Throughput: one point per cycle while the event queue has room. Points
//   that bracket no reported extremum never stall the input.
// Path: after the second point of its pair, a reported extremum passes
//   through the registered rate pipe of the front end and the queue, then
//   the back-end sequencer: a 32-step fraction divide, three multiply/add
//   interpolation steps, the CORDIC iterations and a one-bit-per-cycle
//   square root. The back end takes the next extremum from the queue only
//   once it has handed off the last; the 2-deep queue absorbs bursts.
// Reset: clears the previous point (first point only primes the detector),
//   empties the queue and sets mode_select to report maxima.
// Stall: a held ext beat stays stable; the back end keeps solving the next
//   event, then waits; a full queue holds off pt only on an event point.
// ----------------------------------------------------------------------------
module radial_extremum_finder #(
    parameter int CW = rxf_pkg::COORD_W,
    parameter int AW = rxf_pkg::ANGLE_W,
    parameter int CN = rxf_pkg::CORDIC_N
) (
    input  logic       clk,
    input  logic       rst_n,
    rxf_pt_if.sink     pt,
    rxf_ext_if.source  ext,
    rxf_cfg_if.sink    cfg
);
    import rxf_pkg::*;

    localparam int EW = 6*CW + 2*(2*CW-1) + 1;

    logic          q_push, q_pop, q_full, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    rxf_front #(.CW(CW)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pt     (pt),
        .cfg    (cfg),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    rxf_fifo #(.DW(EW), .DEPTH(2)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    rxf_back #(.CW(CW), .AW(AW), .CN(CN)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .ext     (ext)
    );

endmodule

@@ rtl/rxf_checker.sv @@
// ----------------------------------------------------------------------------
// rxf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rxf_checker #(
    parameter int CW = 32,
    parameter int AW = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [1:0]           cfg_mode,
    input logic                 ext_valid,
    input logic                 ext_ready,
    input logic signed [CW-1:0] cross_time,
    input logic signed [AW-1:0] cross_angle,
    input logic signed [CW-1:0] cross_x,
    input logic signed [CW-1:0] cross_y,
    input logic [CW-1:0]        cross_radius,
    input logic                 is_maximum
);
    import rxf_pkg::*;

    logic [1:0] mode_reg;
    logic [CW:0] xmag, ymag;

    assign xmag = cross_x[CW-1] ? -{cross_x[CW-1], cross_x} : {cross_x[CW-1], cross_x};
    assign ymag = cross_y[CW-1] ? -{cross_y[CW-1], cross_y} : {cross_y[CW-1], cross_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_mode;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid && !ext_ready |=> ext_valid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid && !ext_ready |=> $stable(cross_time) && $stable(cross_angle)
            && $stable(cross_x) && $stable(cross_y) && $stable(cross_radius)
            && $stable(is_maximum))
        else $error("result payload changed while stalled");

    // floor of the radius can never fall below either coordinate magnitude
    a_radius: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid |-> ({1'b0, cross_radius} >= xmag) && ({1'b0, cross_radius} >= ymag))
        else $error("radius below coordinate magnitude");

    a_only_max: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid && (mode_reg == MODE_MAX) |-> is_maximum)
        else $error("minimum reported with maxima only enabled");

    a_only_min: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid && (mode_reg == MODE_MIN) |-> !is_maximum)
        else $error("maximum reported with minima only enabled");

endmodule

bind radial_extremum_finder rxf_checker #(.CW(CW), .AW(AW)) u_rxf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_mode     (cfg.mode_select),
    .ext_valid    (ext.valid),
    .ext_ready    (ext.ready),
    .cross_time   (ext.cross_time),
    .cross_angle  (ext.cross_angle),
    .cross_x      (ext.cross_x),
    .cross_y      (ext.cross_y),
    .cross_radius (ext.cross_radius),
    .is_maximum   (ext.is_maximum)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams orbit points into radial_extremum_finder, predicts every reported
// radial maximum/minimum (interpolated time, angle, x, y, radius) and checks
// each extremum beat in order. Covers all mode settings, rate saturation,
// zero rates, origin and +pi angle cases, random stalls and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import rxf_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t                    cross_time;
        logic signed [ANGLE_W-1:0] cross_angle;
        coord_t                    cross_x;
        coord_t                    cross_y;
        logic [COORD_W-1:0]        cross_radius;
        logic                      is_maximum;
    } extremum_t;

    localparam longint RATE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int     SETTLE   = 160;   // longer than the back-end latency

    // atan(2^-i), units of pi/2^31
    localparam longint ATAN_TAB [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    logic clk;
    logic rst_n;

    rxf_pt_if  #(.CW(COORD_W))              pt_if ();
    rxf_ext_if #(.CW(COORD_W), .AW(ANGLE_W)) ext_if ();
    rxf_cfg_if                              cfg_if ();

    radial_extremum_finder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pt    (pt_if),
        .ext   (ext_if),
        .cfg   (cfg_if)
    );

    // predictor state
    logic [1:0] mode_reg;
    logic       have_prev;
    coord_t     prev_x, prev_y, prev_t;
    longint     prev_rate;

    extremum_t  expected_q [$];
    int         err_cnt;
    int         pt_cnt;
    int         ext_cnt;
    int         max_cnt;
    int         min_cnt;
    logic       pt_hot;      // pt.valid currently held high
    bit         tx_idle;
    bit         rx_idle;
    int         hold_req;
    coord_t     clock_t;

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint radial_rate(coord_t x, coord_t y, coord_t vx, coord_t vy);
        logic signed [65:0] acc;
        acc = x * vx + y * vy;
        if (acc > RATE_MAX)
            return RATE_MAX;
        if (acc < -RATE_MAX)
            return -RATE_MAX;
        return longint'(acc);
    endfunction

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic coord_t interp(coord_t a0, coord_t a1, logic [31:0] f);
        logic signed [33:0] d;
        logic [33:0]        m;
        logic [65:0]        p;
        logic [33:0]        off;
        d   = a1 - a0;
        m   = (d < 0) ? -d : d;
        p   = m * f;
        off = p[65:32];
        return (d < 0) ? coord_t'(a0 - off) : coord_t'(a0 + off);
    endfunction

    function automatic logic [ANGLE_W-1:0] polar_angle(coord_t px, coord_t py);
        longint x, y, z, t, xs, ys;
        x = px;
        y = py;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 1073741824;
            end
            else
            begin
                t = x; x = -y; y = t; z = -1073741824;
            end
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        z = (z + (longint'(1) << (31 - ANGLE_W))) >>> (32 - ANGLE_W);
        return z[ANGLE_W-1:0];
    endfunction

    function automatic logic [31:0] radius_floor(coord_t px, coord_t py);
        logic [63:0] mx, my, n, c;
        logic [31:0] res;
        mx  = mag64(longint'(px));
        my  = mag64(longint'(py));
        n   = mx * mx + my * my;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = {32'd0, res | (32'd1 << b)};
            if (c * c <= n)
                res = c[31:0];
        end
        return res;
    endfunction

    // advance the detector by one accepted point
    task automatic predict_extremum(coord_t x, coord_t y, coord_t vx, coord_t vy, coord_t t);
        longint      s;
        logic        is_max, is_min;
        logic [63:0] a, d, r;
        logic [31:0] f;
        logic        carry;
        extremum_t   e;
        s = radial_rate(x, y, vx, vy);
        if (have_prev)
        begin
            is_max = prev_rate > 0 && s < 0;
            is_min = prev_rate < 0 && s > 0;
            if ((is_max && (mode_reg & MODE_MAX) != 0) || (is_min && (mode_reg & MODE_MIN) != 0))
            begin
                a = mag64(prev_rate);
                d = a + mag64(s);
                r = a;
                f = 0;
                for (int k = 0; k < 32; k++)
                begin
                    carry = r[63];
                    r     = r << 1;
                    f     = f << 1;
                    if (carry || r >= d)
                    begin
                        r    = r - d;
                        f[0] = 1'b1;
                    end
                end
                e.cross_x      = interp(prev_x, x, f);
                e.cross_y      = interp(prev_y, y, f);
                e.cross_time   = interp(prev_t, t, f);
                e.cross_angle  = polar_angle(e.cross_x, e.cross_y);
                e.cross_radius = radius_floor(e.cross_x, e.cross_y);
                e.is_maximum   = is_max;
                expected_q.push_back(e);
            end
        end
        have_prev = 1'b1;
        prev_x    = x;
        prev_y    = y;
        prev_rate = s;
        prev_t    = t;
    endtask

    // ---------------- driving ----------------
    task automatic send_point(coord_t x, coord_t y, coord_t vx, coord_t vy, coord_t t);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            if (pt_hot)
                pt_if.valid <= 1'b0;
            pt_hot = 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_if.valid       <= 1'b1;
        pt_if.pos_x       <= x;
        pt_if.pos_y       <= y;
        pt_if.vel_x       <= vx;
        pt_if.vel_y       <= vy;
        pt_if.sample_time <= t;
        pt_hot = 1'b1;
        do @(posedge clk); while (!pt_if.ready);
        predict_extremum(x, y, vx, vy, t);
        pt_cnt++;
    endtask

    task automatic wait_drained();
        if (pt_hot)
            pt_if.valid <= 1'b0;
        pt_hot = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.mode_select <= m;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        mode_reg = m;
    endtask

    // random orbit point; rate sign follows want_sign where possible
    task automatic random_point(int want_sign);
        coord_t x, y, vx, vy;
        longint s;
        int     kind;
        kind = $urandom_range(0, 19);
        clock_t = clock_t + coord_t'($urandom_range(1, 1 << 17));
        if (kind == 0)
        begin
            // unshaped noise over the full range
            send_point($urandom, $urandom, $urandom, $urandom, $urandom);
            return;
        end
        if (kind == 1)
        begin
            x  = $urandom_range(0, 1 << 22) - (1 << 21);
            y  = $urandom_range(0, 1 << 22) - (1 << 21);
            send_point(x, y, 0, 0, clock_t);
            return;
        end
        if (kind < 4)
        begin
            x  = $urandom; y  = $urandom;
            vx = $urandom; vy = $urandom;
        end
        else
        begin
            x  = $urandom_range(0, 1 << 22) - (1 << 21);
            y  = $urandom_range(0, 1 << 22) - (1 << 21);
            vx = $urandom_range(0, 1 << 20) - (1 << 19);
            vy = $urandom_range(0, 1 << 20) - (1 << 19);
        end
        s = radial_rate(x, y, vx, vy);
        if ((want_sign > 0 && s < 0) || (want_sign < 0 && s > 0))
        begin
            vx = -vx;
            vy = -vy;
        end
        send_point(x, y, vx, vy, kind < 4 ? coord_t'($urandom) : clock_t);
    endtask

    task automatic random_run(int n, bit flip_each);
        int sgn;
        sgn = 1;
        for (int i = 0; i < n; i++)
        begin
            if (flip_each || $urandom_range(0, 2) == 0)
                sgn = -sgn;
            random_point(sgn);
        end
    endtask

    // ---------------- result checking ----------------
    initial
    begin
        extremum_t e;
        int        stall;
        ext_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
                stall = hold_req;
            else
                stall = rx_idle ? $urandom_range(0, 9) : 0;
            hold_req = 0;
            if (stall > 0)
            begin
                ext_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            ext_if.ready <= 1'b1;
            do @(posedge clk); while (!ext_if.valid);
            ext_cnt++;
            if (expected_q.size() == 0)
            begin
                $error("extremum beat with nothing expected");
                err_cnt++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.is_maximum) max_cnt++; else min_cnt++;
                if (ext_if.cross_time !== e.cross_time)
                begin
                    $error("cross_time exp %0d got %0d", e.cross_time, ext_if.cross_time);
                    err_cnt++;
                end
                if (ext_if.cross_angle !== e.cross_angle)
                begin
                    $error("cross_angle exp %0d got %0d", e.cross_angle, ext_if.cross_angle);
                    err_cnt++;
                end
                if (ext_if.cross_x !== e.cross_x)
                begin
                    $error("cross_x exp %0d got %0d", e.cross_x, ext_if.cross_x);
                    err_cnt++;
                end
                if (ext_if.cross_y !== e.cross_y)
                begin
                    $error("cross_y exp %0d got %0d", e.cross_y, ext_if.cross_y);
                    err_cnt++;
                end
                if (ext_if.cross_radius !== e.cross_radius)
                begin
                    $error("cross_radius exp %0d got %0d", e.cross_radius,
                           ext_if.cross_radius);
                    err_cnt++;
                end
                if (ext_if.is_maximum !== e.is_maximum)
                begin
                    $error("is_maximum exp %0d got %0d", e.is_maximum, ext_if.is_maximum);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // first point only primes; reset mode reports maxima only
        send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0, 0);
        send_point(32'sh0002_0000, 0, -32'sh0001_0000, 0, 32'sh0001_0000);
        send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0, 32'sh0002_0000);  // min, masked
        write_mode(MODE_MAX | MODE_MIN);
        // zero rate on either side: no strict change
        send_point(32'sh0001_0000, 0, 0, 0, 32'sh0003_0000);
        send_point(32'sh0001_0000, 0, -32'sh0001_0000, 0, 32'sh0004_0000);
        send_point(32'sh0001_0000, 0, 0, 0, 32'sh0005_0000);
        send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0, 32'sh0006_0000);
        // crossing through the origin: angle 0
        send_point(-32'sh0001_0000, 0, -32'sh0001_0000, 0, 32'sh0007_0000);
        send_point(32'sh0001_0000, 0, -32'sh0001_0000, 0, 32'sh0008_0000);
        // crossing on the negative x axis: +pi wraps to -pi
        send_point(-32'sh0003_0000, 0, 32'sh0001_0000, 0, 32'sh0009_0000);
        send_point(-32'sh0001_0000, 0, -32'sh0001_0000, 0, 32'sh000A_0000);
        // full-scale coordinates: a saturated positive rate, large rates of both signs
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh7FFF_FFFF);
        send_point(-1, -1, -1, -1, -1);
        send_point(-1, 0, 1, 0, 0);
        write_mode(2'b00);
        send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0, 0);
        send_point(32'sh0001_0000, 0, -32'sh0001_0000, 0, 1);
        send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0, 2);
    endtask

    task automatic test_random_modes();
        logic [1:0] modes [5] = '{2'b11, 2'b10, 2'b00, 2'b01, 2'b11};
        foreach (modes[i])
        begin
            write_mode(modes[i]);
            tx_idle = (i != 1);
            rx_idle = (i != 3);
            random_run(190, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        write_mode(MODE_MAX | MODE_MIN);
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 3000;
        random_run(80, 1'b1);
        wait_drained();       // sender pause until every extremum is out
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_run(100, 1'b1);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n     <= 1'b0;
        pt_if.valid       <= 1'b0;
        pt_if.pos_x       <= '0;
        pt_if.pos_y       <= '0;
        pt_if.vel_x       <= '0;
        pt_if.vel_y       <= '0;
        pt_if.sample_time <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.mode_select <= '0;
        mode_reg  = MODE_RESET;
        have_prev = 1'b0;
        prev_x    = 0;
        prev_y    = 0;
        prev_t    = 0;
        prev_rate = 0;
        err_cnt   = 0;
        pt_cnt    = 0;
        ext_cnt   = 0;
        max_cnt   = 0;
        min_cnt   = 0;
        pt_hot    = 1'b0;
        hold_req  = 0;
        clock_t   = 0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_modes();
        test_backpressure();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d orbit points: directed under modes 1,3,0, random under 3,2,0,1,3",
                 pt_cnt);
        $display("and a long result stall under 3; checked %0d extrema: %0d maxima, %0d minima",
                 ext_cnt, max_cnt, min_cnt);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rxf_pkg.sv
rtl/rxf_if.sv
rtl/rxf_front.sv
rtl/rxf_fifo.sv
rtl/rxf_back.sv
rtl/radial_extremum_finder.sv
rtl/rxf_checker.sv
tb/tb_top.sv
